// ----- rtl/cfp_pkg.sv -----
// Package for the CRC-checked command frame parser.
// Holds the phase and event codes, register indexes, shared structs and constants.
// No dependencies.
`default_nettype none

package cfp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CRC_W   = 16;
    localparam int unsigned TOKEN_W = 64;
    localparam int unsigned CFG_A_W = 3;
    localparam int unsigned OUT_W   = 16;

    localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA001;
    localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
    localparam logic [BYTE_W-1:0] ID_BYTES = 8'd8;

    localparam logic [TOKEN_W-1:0] RST_AUTH_TOKEN = 64'd6364207704511098177;
    localparam logic [BYTE_W-1:0]  RST_VERSION    = 8'h02;
    localparam logic [BYTE_W-1:0]  RST_ADDRESS    = 8'h7E;
    localparam logic [BYTE_W-1:0]  RST_KIND       = 8'h7F;
    localparam logic [BYTE_W-1:0]  RST_MARK       = 8'h40;

    localparam logic [CFG_A_W-1:0] CFG_AUTH_TOKEN = 3'd0;
    localparam logic [CFG_A_W-1:0] CFG_VERSION    = 3'd1;
    localparam logic [CFG_A_W-1:0] CFG_ADDRESS    = 3'd2;
    localparam logic [CFG_A_W-1:0] CFG_KIND       = 3'd3;
    localparam logic [CFG_A_W-1:0] CFG_MARK       = 3'd4;

    typedef enum logic [9:0] {
        PH_WAIT     = 10'b00_0000_0001,
        PH_ID       = 10'b00_0000_0010,
        PH_VERSION  = 10'b00_0000_0100,
        PH_ADDRESS  = 10'b00_0000_1000,
        PH_KIND     = 10'b00_0001_0000,
        PH_LENGTH   = 10'b00_0010_0000,
        PH_COMMAND  = 10'b00_0100_0000,
        PH_CRC_LOW  = 10'b00_1000_0000,
        PH_CRC_HIGH = 10'b01_0000_0000,
        PH_END      = 10'b10_0000_0000
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_ACCEPTED = 3'd1,
        EV_HEADER   = 3'd2,
        EV_END_MARK = 3'd3,
        EV_TOKEN    = 3'd4,
        EV_CRC      = 3'd5
    } t_event;

    typedef struct packed {
        logic [TOKEN_W-1:0] auth_token;
        logic [BYTE_W-1:0]  version;
        logic [BYTE_W-1:0]  address;
        logic [BYTE_W-1:0]  kind;
        logic [BYTE_W-1:0]  mark;
    } t_cfg;

    typedef struct packed {
        logic               idle;
        logic [BYTE_W-1:0]  command;
        t_event             frame_event;
        logic               consumed;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/cfp_crc_fold.sv -----
// One-byte MODBUS CRC16 update, unrolled over the eight bit steps.
// Depends on cfp_pkg.
`default_nettype none

module cfp_crc_fold
    import cfp_pkg::*;
(
    input  wire logic [CRC_W-1:0]  i_crc,
    input  wire logic [BYTE_W-1:0] i_byte,
    output logic      [CRC_W-1:0]  o_crc
);

    always_comb begin
        logic [CRC_W-1:0] v_crc;
        v_crc = i_crc ^ {{(CRC_W-BYTE_W){1'b0}}, i_byte};
        for (int k = 0; k < BYTE_W; k++) begin
            if (v_crc[0]) begin
                v_crc = (v_crc >> 1) ^ CRC_POLY;
            end else begin
                v_crc = v_crc >> 1;
            end
        end
        o_crc = v_crc;
    end

endmodule

`default_nettype wire

// ----- rtl/cfp_frame_fsm.sv -----
// Frame phase sequencer: holds the parse state, running CRC and device id,
// and works out the result for the byte in the input register. Depends on cfp_pkg, cfp_crc_fold.
`default_nettype none

module cfp_frame_fsm
    import cfp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire t_cfg              i_cfg,
    output t_result                o_result
);

    t_phase              r_phase, n_phase;
    logic [BYTE_W-1:0]   r_count, n_count;
    logic [BYTE_W-1:0]   r_len, n_len;
    logic [BYTE_W-1:0]   r_last, n_last;
    logic [TOKEN_W-1:0]  r_dev_id, n_dev_id;
    logic [CRC_W-1:0]    r_crc, n_crc;
    logic [CRC_W-1:0]    r_rx_crc, n_rx_crc;
    logic [CRC_W-1:0]    crc_next;
    logic [BYTE_W-1:0]   count_inc;
    logic [BYTE_W-1:0]   want;

    cfp_crc_fold u_crc (
        .i_crc  (r_crc),
        .i_byte (i_byte),
        .o_crc  (crc_next)
    );

    assign count_inc = r_count + 8'd1;

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_len    = r_len;
        n_last   = r_last;
        n_dev_id = r_dev_id;
        n_crc    = r_crc;
        n_rx_crc = r_rx_crc;
        o_result.consumed    = 1'b1;
        o_result.frame_event = EV_NONE;
        o_result.command     = '0;
        want = i_cfg.kind;
        if (r_phase == PH_VERSION) begin
            want = i_cfg.version;
        end else if (r_phase == PH_ADDRESS) begin
            want = i_cfg.address;
        end

        unique case (r_phase) inside
            PH_ID: begin
                n_dev_id = {r_dev_id[TOKEN_W-BYTE_W-1:0], i_byte};
                n_crc    = crc_next;
                n_count  = count_inc;
                if (count_inc >= ID_BYTES) begin
                    n_phase = PH_VERSION;
                end
            end
            PH_VERSION, PH_ADDRESS, PH_KIND: begin
                if (i_byte != want) begin
                    n_phase = PH_WAIT;
                    o_result.frame_event = EV_HEADER;
                end else begin
                    n_crc = crc_next;
                    if (r_phase == PH_VERSION) begin
                        n_phase = PH_ADDRESS;
                    end else if (r_phase == PH_ADDRESS) begin
                        n_phase = PH_KIND;
                    end else begin
                        n_phase = PH_LENGTH;
                    end
                end
            end
            PH_LENGTH: begin
                n_len   = i_byte;
                n_crc   = crc_next;
                n_count = '0;
                n_phase = (i_byte == '0) ? PH_CRC_LOW : PH_COMMAND;
            end
            PH_COMMAND: begin
                n_last  = i_byte;
                n_crc   = crc_next;
                n_count = count_inc;
                if (count_inc >= r_len) begin
                    n_phase = PH_CRC_LOW;
                end
            end
            PH_CRC_LOW: begin
                n_rx_crc = {{(CRC_W-BYTE_W){1'b0}}, i_byte};
                n_phase  = PH_CRC_HIGH;
            end
            PH_CRC_HIGH: begin
                n_rx_crc = {i_byte, r_rx_crc[BYTE_W-1:0]};
                n_phase  = PH_END;
            end
            PH_END: begin
                if (i_byte != i_cfg.mark) begin
                    o_result.frame_event = EV_END_MARK;
                end else if (r_dev_id != i_cfg.auth_token) begin
                    o_result.frame_event = EV_TOKEN;
                end else if (r_crc != r_rx_crc) begin
                    o_result.frame_event = EV_CRC;
                end else begin
                    o_result.frame_event = EV_ACCEPTED;
                    o_result.command     = r_last;
                end
                n_phase = PH_WAIT;
            end
            default: begin
                if (i_byte == i_cfg.mark) begin
                    n_count = '0;
                    n_crc   = CRC_INIT;
                    n_phase = PH_ID;
                end else begin
                    n_phase = PH_WAIT;
                    o_result.consumed = 1'b0;
                end
            end
        endcase
        o_result.idle = (n_phase == PH_WAIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_WAIT;
            r_count  <= '0;
            r_len    <= '0;
            r_last   <= '0;
            r_crc    <= CRC_INIT;
            r_rx_crc <= '0;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_len    <= n_len;
            r_last   <= n_last;
            r_crc    <= n_crc;
            r_rx_crc <= n_rx_crc;
        end
    end

    // The device id is always fully shifted in before it is compared.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dev_id <= n_dev_id;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/crc_checked_command_frame_parser_core.sv -----
// A byte is held in the input register; its result is registered in the output register when it advances.
// Throughput: one byte per cycle while the output is not stalled, set by the combinational CRC fold and phase update.
// A byte is taken while an earlier result waits; the input register is the skid stage.
// Reset is synchronous and active low: the parser goes idle with the CRC at 0xFFFF
// and all configuration registers return to their default values.
// Depends on cfp_pkg and cfp_frame_fsm.
`default_nettype none

module crc_checked_command_frame_parser_core
    import cfp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  wire logic [BYTE_W-1:0]  i_s_axis_tdata,  // [7:0] rx_byte
    output logic                    o_m_axis_tvalid,
    input  wire logic               i_m_axis_tready,
    output logic [OUT_W-1:0]        o_m_axis_tdata,  // [0] consumed, [3:1] frame_event,
                                                     // [11:4] command, [12] idle, rest zero
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_A_W-1:0] i_cfg_addr,
    input  wire logic [TOKEN_W-1:0] i_cfg_wdata
);

    t_cfg              r_cfg;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_result;
    t_result           fsm_result;
    logic              advance;
    logic              in_take;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.auth_token <= RST_AUTH_TOKEN;
            r_cfg.version    <= RST_VERSION;
            r_cfg.address    <= RST_ADDRESS;
            r_cfg.kind       <= RST_KIND;
            r_cfg.mark       <= RST_MARK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_AUTH_TOKEN: r_cfg.auth_token <= i_cfg_wdata;
                CFG_VERSION:    r_cfg.version    <= i_cfg_wdata[BYTE_W-1:0];
                CFG_ADDRESS:    r_cfg.address    <= i_cfg_wdata[BYTE_W-1:0];
                CFG_KIND:       r_cfg.kind       <= i_cfg_wdata[BYTE_W-1:0];
                CFG_MARK:       r_cfg.mark       <= i_cfg_wdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    cfp_frame_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_result (fsm_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_m_axis_tready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= fsm_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_W-$bits(t_result)){1'b0}}, r_result};

`ifndef SYNTHESIS
    a_unconsumed_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_result.consumed |-> r_result.idle && r_result.frame_event == EV_NONE)
        else $error("unconsumed byte left the parser busy");

    a_event_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.frame_event != EV_NONE |-> r_result.idle)
        else $error("frame outcome reported while parser stays busy");

    a_command_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.frame_event != EV_ACCEPTED |-> r_result.command == '0)
        else $error("command set without an accepted frame");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_m_axis_tready |=> r_in_valid && r_out_valid)
        else $error("request lost while output stalled");
`endif

endmodule

`default_nettype wire
